FILE: rtl/dsv_pkg.sv
// Shared types, constants and helpers for the date string validator.
// No dependencies; used by dsv_parse, dsv_check and date_string_validator.
package dsv_pkg;

  // Position and character constants of the "dd/mm/yyyy" form
  localparam logic [3:0] DATE_LEN = 4'd10;
  localparam logic [3:0] POS_SAT  = 4'd11;
  localparam logic [3:0] POS_SEP0 = 4'd2;
  localparam logic [3:0] POS_SEP1 = 4'd5;
  localparam logic [3:0] POS_YH0  = 4'd6;
  localparam logic [3:0] POS_YH1  = 4'd7;
  localparam logic [3:0] POS_YL0  = 4'd8;
  localparam logic [3:0] POS_YL1  = 4'd9;
  localparam logic [7:0] SEP_CHAR = 8'h2F;

  localparam logic [6:0] MONTH_MAX = 7'd12;
  localparam logic [6:0] MONTH_FEB = 7'd2;
  localparam logic [6:0] MONTH_APR = 7'd4;
  localparam logic [6:0] MONTH_JUN = 7'd6;
  localparam logic [6:0] MONTH_SEP = 7'd9;
  localparam logic [6:0] MONTH_NOV = 7'd11;

  // Result status codes, in check priority order
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_LENGTH    = 3'd1,
    ST_SEPARATOR = 3'd2,
    ST_DIGIT     = 3'd3,
    ST_YEAR_ZERO = 3'd4,
    ST_MONTH     = 3'd5,
    ST_DAY       = 3'd6
  } status_t;

  // Parse state: position, sticky errors and decimal accumulators.
  // year_hi/year_lo hold the century and the last two digits of the year.
  typedef struct packed {
    logic [3:0]  position;
    logic        sep_err;
    logic        dig_err;
    logic [6:0]  day;
    logic [6:0]  month;
    logic [13:0] year;
    logic [6:0]  year_hi;
    logic [6:0]  year_lo;
  } parse_t;

  // x * 10 + d, kept to 7 bits
  function automatic logic [6:0] mac10_7(input logic [6:0] x, input logic [3:0] d);
    logic [10:0] s;
    s = 11'({x, 3'b000}) + 11'({x, 1'b0}) + 11'(d);
    return s[6:0];
  endfunction

  // x * 10 + d, kept to 14 bits
  function automatic logic [13:0] mac10_14(input logic [13:0] x, input logic [3:0] d);
    logic [17:0] s;
    s = 18'({x, 3'b000}) + 18'({x, 1'b0}) + 18'(d);
    return s[13:0];
  endfunction

  // Days in a month, February by leap flag
  function automatic logic [4:0] month_days(input logic [6:0] m, input logic leap);
    logic [4:0] n;
    if (m == MONTH_FEB) begin
      n = leap ? 5'd29 : 5'd28;
    end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
      n = 5'd30;
    end else begin
      n = 5'd31;
    end
    return n;
  endfunction

endpackage

FILE: rtl/date_string_validator.sv
// Date string validator for the "dd/mm/yyyy" form.
// Input register, parser and checker, output register.
//
// Usage:
//   Feed the string one ASCII character per item on the in_ channel and
//   mark the final character with in_last_char. Each string gives exactly
//   one item on the out_ channel: valid flag, status code and, when valid,
//   the parsed day, month and year (zero otherwise).
//   The final character waits in the input register, and its result is
//   registered in the output register once that register is free. Throughput:
//   one character per cycle while in_stall is low, with no gap between strings;
//   the parse state clears as the final character passes the parser.
//   Reset (rst_n low, synchronous) empties both registers and clears the
//   parse state, so a partial string is dropped.
//   When out_stall holds a waiting result, characters that produce no
//   result keep flowing; only the next final character waits in the input
//   register, and in_stall rises once that register is occupied.
module date_string_validator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_character,
  input  logic        in_last_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_valid_res,
  output logic [2:0]  out_status,
  output logic [4:0]  out_day_value,
  output logic [3:0]  out_month_value,
  output logic [13:0] out_year_value
);

  logic             s1_valid_r;
  logic             s1_valid_nxt;
  logic [7:0]       s1_char_r;
  logic             s1_last_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             out_valid_res_r;
  dsv_pkg::status_t out_status_r;
  logic [4:0]       out_day_r;
  logic [3:0]       out_month_r;
  logic [13:0]      out_year_r;

  logic             accept;
  logic             out_ready;
  logic             s1_go;
  dsv_pkg::parse_t  upd;
  logic             chk_valid;
  dsv_pkg::status_t chk_status;
  logic [4:0]       chk_day;
  logic [3:0]       chk_month;
  logic [13:0]      chk_year;

  // Handshake: a final character moves only when the output register frees
  always_comb begin
    out_ready     = !out_valid_r || !out_stall;
    s1_go         = s1_valid_r && (!s1_last_r || out_ready);
    in_stall      = s1_valid_r && !s1_go;
    accept        = in_valid && !in_stall;
    s1_valid_nxt  = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
    out_valid_nxt = (s1_go && s1_last_r) ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_char_r <= in_character;
      s1_last_r <= in_last_char;
    end
  end

  dsv_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_go),
    .character (s1_char_r),
    .last_char (s1_last_r),
    .upd       (upd)
  );

  dsv_check u_check (
    .st          (upd),
    .valid_res   (chk_valid),
    .status      (chk_status),
    .day_value   (chk_day),
    .month_value (chk_month),
    .year_value  (chk_year)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_valid_res_r <= chk_valid;
      out_status_r    <= chk_status;
      out_day_r       <= chk_day;
      out_month_r     <= chk_month;
      out_year_r      <= chk_year;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_valid_res   = out_valid_res_r;
  assign out_status      = out_status_r;
  assign out_day_value   = out_day_r;
  assign out_month_value = out_month_r;
  assign out_year_value  = out_year_r;

  // Input stalls only behind a final character blocked by a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s1_last_r && out_valid_r && out_stall)
    else $error("input stalled without a blocked result");

  // Valid flag agrees with the status
  a_valid_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_valid_res == (out_status == dsv_pkg::ST_OK)))
    else $error("valid flag and status disagree");

  // Rejected strings carry a zero date
  a_zero_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |->
      out_day_value == 5'd0 && out_month_value == 4'd0 && out_year_value == 14'd0)
    else $error("rejected string carries a date");

  // Accepted dates lie in range
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |-> out_day_value != 5'd0 && out_month_value != 4'd0 &&
      out_month_value <= 4'd12 && out_year_value != 14'd0)
    else $error("accepted date out of range");

endmodule

FILE: rtl/dsv_parse.sv
// Character parser: position counter, sticky error flags and accumulators.
// Depends on dsv_pkg. Presents the state as updated by the current character.
module dsv_parse (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic [7:0]      character,
  input  logic            last_char,
  output dsv_pkg::parse_t upd
);

  dsv_pkg::parse_t state_r;
  dsv_pkg::parse_t state_nxt;
  logic            is_digit;
  logic [3:0]      digit;
  logic [3:0]      pos;

  // Fold one character into the state
  always_comb begin
    pos      = state_r.position;
    upd      = state_r;
    is_digit = character inside {[8'h30:8'h39]};
    digit    = character[3:0];
    if (pos < dsv_pkg::DATE_LEN) begin
      if (pos == dsv_pkg::POS_SEP0 || pos == dsv_pkg::POS_SEP1) begin
        if (character != dsv_pkg::SEP_CHAR) begin
          upd.sep_err = 1'b1;
        end
      end else if (!is_digit) begin
        upd.dig_err = 1'b1;
      end else begin
        if (pos < dsv_pkg::POS_SEP0) begin
          upd.day = dsv_pkg::mac10_7(state_r.day, digit);
        end else if (pos < dsv_pkg::POS_SEP1) begin
          upd.month = dsv_pkg::mac10_7(state_r.month, digit);
        end else begin
          upd.year = dsv_pkg::mac10_14(state_r.year, digit);
        end
        // Split the year into century and last two digits for the leap test
        if (pos == dsv_pkg::POS_YH0 || pos == dsv_pkg::POS_YH1) begin
          upd.year_hi = dsv_pkg::mac10_7(state_r.year_hi, digit);
        end
        if (pos == dsv_pkg::POS_YL0 || pos == dsv_pkg::POS_YL1) begin
          upd.year_lo = dsv_pkg::mac10_7(state_r.year_lo, digit);
        end
      end
    end
    if (pos < dsv_pkg::POS_SAT) begin
      upd.position = pos + 4'd1;
    end
  end

  // On a step, clear after the final character, else advance; hold without a step
  always_comb begin
    state_nxt = state_r;
    if (step) begin
      state_nxt = last_char ? '0 : upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Position never passes saturation
  a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.position <= dsv_pkg::POS_SAT)
    else $error("position past saturation");

  // A final character leaves the state cleared
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    step && last_char |=> state_r.position == 4'd0 && !state_r.sep_err && !state_r.dig_err)
    else $error("state not cleared after final character");

  // Sticky errors only set while inside the ten positions
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    step && !last_char && state_r.position >= dsv_pkg::DATE_LEN |=>
      $stable(state_r.sep_err) && $stable(state_r.dig_err))
    else $error("error flag changed past the date length");

endmodule

FILE: rtl/dsv_check.sv
// Final verdict: status by priority, leap year rule and gated date fields.
// Depends on dsv_pkg; purely combinational on the updated parse state.
module dsv_check (
  input  dsv_pkg::parse_t  st,
  output logic             valid_res,
  output dsv_pkg::status_t status,
  output logic [4:0]       day_value,
  output logic [3:0]       month_value,
  output logic [13:0]      year_value
);

  logic       leap;
  logic [4:0] mdays;
  logic       lo_zero;

  // Gregorian rule from the century and the last two digits
  always_comb begin
    lo_zero = (st.year_lo == 7'd0);
    leap    = (!lo_zero && st.year_lo[1:0] == 2'd0) ||
              (lo_zero && st.year_hi[1:0] == 2'd0);
    mdays   = dsv_pkg::month_days(st.month, leap);
  end

  // First failing check sets the status
  always_comb begin
    if (st.position != dsv_pkg::DATE_LEN) begin
      status = dsv_pkg::ST_LENGTH;
    end else if (st.sep_err) begin
      status = dsv_pkg::ST_SEPARATOR;
    end else if (st.dig_err) begin
      status = dsv_pkg::ST_DIGIT;
    end else if (st.year == 14'd0) begin
      status = dsv_pkg::ST_YEAR_ZERO;
    end else if (st.month == 7'd0 || st.month > dsv_pkg::MONTH_MAX) begin
      status = dsv_pkg::ST_MONTH;
    end else if (st.day == 7'd0 || st.day > {2'b00, mdays}) begin
      status = dsv_pkg::ST_DAY;
    end else begin
      status = dsv_pkg::ST_OK;
    end
    valid_res   = (status == dsv_pkg::ST_OK);
    day_value   = valid_res ? st.day[4:0]   : 5'd0;
    month_value = valid_res ? st.month[3:0] : 4'd0;
    year_value  = valid_res ? st.year       : 14'd0;
  end

endmodule

FILE: verif/date_string_validator_test.sv
// Self-checking testbench for date_string_validator: drives "dd/mm/yyyy" strings, checks results.
// Depends on rtl/dsv_pkg.sv (status codes, position constants) and the date_string_validator RTL.
// A scoreboard class predicts one result per final character and checks the out_ channel.
module date_string_validator_test;
  timeunit 1ns;
  timeprecision 1ps;

  // One expected verdict on the out_ channel
  typedef struct {
    logic             valid_res;
    dsv_pkg::status_t status;
    logic [4:0]       day;
    logic [3:0]       month;
    logic [13:0]      year;
  } date_result_t;

  // Date parser prediction and result queue
  class date_scoreboard;
    logic [3:0]   position;
    logic         sep_err;
    logic         dig_err;
    logic [6:0]   day_acc;
    logic [6:0]   month_acc;
    logic [13:0]  year_acc;
    date_result_t expected_q[$];
    int           errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      position  = '0;
      sep_err   = 1'b0;
      dig_err   = 1'b0;
      day_acc   = '0;
      month_acc = '0;
      year_acc  = '0;
    endfunction

    function bit leap_year(int unsigned y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function int unsigned days_in(int unsigned m, int unsigned y);
      if (m == 2) return leap_year(y) ? 29 : 28;
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      return 31;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advance the parse state by one accepted character
    function void note_char(logic [7:0] ch, logic last);
      logic [3:0]       digit;
      dsv_pkg::status_t st;
      date_result_t     r;
      digit = 4'(ch - 8'h30);
      if (position < dsv_pkg::DATE_LEN) begin
        if (position == dsv_pkg::POS_SEP0 || position == dsv_pkg::POS_SEP1) begin
          if (ch != dsv_pkg::SEP_CHAR) sep_err = 1'b1;
        end else if (ch < 8'h30 || ch > 8'h39) begin
          dig_err = 1'b1;
        end else if (position < dsv_pkg::POS_SEP0) begin
          day_acc = 7'(day_acc * 10 + digit);
        end else if (position < dsv_pkg::POS_SEP1) begin
          month_acc = 7'(month_acc * 10 + digit);
        end else begin
          year_acc = 14'(year_acc * 10 + digit);
        end
      end
      if (position < dsv_pkg::POS_SAT) position = position + 4'd1;
      if (!last) return;

      // Checks in priority order: length, separator, digit, year, month, day
      if (position != dsv_pkg::DATE_LEN) st = dsv_pkg::ST_LENGTH;
      else if (sep_err) st = dsv_pkg::ST_SEPARATOR;
      else if (dig_err) st = dsv_pkg::ST_DIGIT;
      else if (year_acc == 0) st = dsv_pkg::ST_YEAR_ZERO;
      else if (month_acc < 1 || month_acc > 12) st = dsv_pkg::ST_MONTH;
      else if (day_acc < 1 || day_acc > days_in(month_acc, year_acc)) st = dsv_pkg::ST_DAY;
      else st = dsv_pkg::ST_OK;

      r.valid_res = (st == dsv_pkg::ST_OK);
      r.status    = st;
      r.day       = (st == dsv_pkg::ST_OK) ? day_acc[4:0] : 5'd0;
      r.month     = (st == dsv_pkg::ST_OK) ? month_acc[3:0] : 4'd0;
      r.year      = (st == dsv_pkg::ST_OK) ? year_acc : 14'd0;
      expected_q.push_back(r);
      clear();
    endfunction

    // Compare one accepted result against the oldest prediction
    function void check_result(logic vr, logic [2:0] st, logic [4:0] d, logic [3:0] m,
                               logic [13:0] y);
      date_result_t r;
      if (expected_q.size() == 0) begin
        $error("unexpected result: status %0d day %0d month %0d year %0d", st, d, m, y);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      if (vr !== r.valid_res) begin
        $error("valid_res: expected %0d, got %0d", r.valid_res, vr);
        errors++;
      end
      if (st !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, st);
        errors++;
      end
      if (d !== r.day) begin
        $error("day_value: expected %0d, got %0d", r.day, d);
        errors++;
      end
      if (m !== r.month) begin
        $error("month_value: expected %0d, got %0d", r.month, m);
        errors++;
      end
      if (y !== r.year) begin
        $error("year_value: expected %0d, got %0d", r.year, y);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_character;
  logic        in_last_char;
  logic        out_valid;
  logic        out_stall;
  logic        out_valid_res;
  logic [2:0]  out_status;
  logic [4:0]  out_day_value;
  logic [3:0]  out_month_value;
  logic [13:0] out_year_value;

  date_scoreboard sb;
  logic [7:0]     text_q[$];
  int             gap_pct;
  int             chars_sent;
  int             strings_sent;

  date_string_validator DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_character   (in_character),
    .in_last_char   (in_last_char),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_valid_res  (out_valid_res),
    .out_status     (out_status),
    .out_day_value  (out_day_value),
    .out_month_value(out_month_value),
    .out_year_value (out_year_value)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Load a literal string into the text buffer
  function automatic void set_text(string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(8'(s[i]));
  endfunction

  // Write d, m, y as "dd/mm/yyyy"
  function automatic void push_date(int unsigned d, int unsigned m, int unsigned y);
    text_q.delete();
    text_q.push_back(8'(48 + d / 10));
    text_q.push_back(8'(48 + d % 10));
    text_q.push_back(dsv_pkg::SEP_CHAR);
    text_q.push_back(8'(48 + m / 10));
    text_q.push_back(8'(48 + m % 10));
    text_q.push_back(dsv_pkg::SEP_CHAR);
    text_q.push_back(8'(48 + y / 1000));
    text_q.push_back(8'(48 + (y / 100) % 10));
    text_q.push_back(8'(48 + (y / 10) % 10));
    text_q.push_back(8'(48 + y % 10));
  endfunction

  // Bias years toward the leap rule's corners
  function automatic int unsigned pick_year();
    int unsigned y;
    case ($urandom_range(3))
      0: y = $urandom_range(9999, 1);
      1: y = 4 * $urandom_range(2499, 1);
      2: y = 100 * $urandom_range(99, 1);
      default: y = 400 * $urandom_range(24, 1);
    endcase
    return y;
  endfunction

  function automatic logic [7:0] non_digit();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b >= 8'h30 && b <= 8'h39);
    return b;
  endfunction

  function automatic logic [7:0] non_slash();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == dsv_pkg::SEP_CHAR);
    return b;
  endfunction

  // Build one random string: mostly well-formed dates, then targeted breakage
  function automatic void build_random_string();
    int unsigned kind;
    int unsigned d;
    int unsigned m;
    int unsigned y;
    int unsigned p;
    kind = $urandom_range(99);
    y = pick_year();
    m = $urandom_range(12, 1);
    d = $urandom_range(sb.days_in(m, y), 1);
    if (kind < 8) begin
      // end of February around leap years
      m = 2;
      d = $urandom_range(30, 28);
    end else if (kind >= 40 && kind < 50) begin
      d = ($urandom_range(3) == 0) ? 0 : $urandom_range(99, sb.days_in(m, y) + 1);
    end else if (kind >= 50 && kind < 58) begin
      m = ($urandom_range(2) == 0) ? 0 : $urandom_range(99, 13);
      d = $urandom_range(99);
    end else if (kind >= 58 && kind < 63) begin
      y = 0;
      m = $urandom_range(99);
      d = $urandom_range(99);
    end
    push_date(d, m, y);

    if (kind >= 63 && kind < 71) begin
      // corrupt one digit position
      do p = $urandom_range(9); while (p == 2 || p == 5);
      text_q[p] = non_digit();
    end else if (kind >= 71 && kind < 78) begin
      // corrupt a separator, sometimes with a digit fault too
      text_q[($urandom_range(1) == 0) ? 2 : 5] = non_slash();
      if ($urandom_range(1) == 0) text_q[$urandom_range(1)] = non_digit();
    end else if (kind >= 78 && kind < 86) begin
      // truncate
      p = $urandom_range(9, 1);
      while (text_q.size() > p) void'(text_q.pop_back());
    end else if (kind >= 86 && kind < 93) begin
      // overrun past the saturating position
      repeat ($urandom_range(4, 1)) text_q.push_back(8'($urandom_range(255)));
    end else if (kind >= 93) begin
      // raw noise of 1 to 14 characters
      text_q.delete();
      repeat ($urandom_range(14, 1)) text_q.push_back(8'($urandom_range(255)));
    end
  endfunction

  // Send the text buffer, one character per item, last flag on the final one
  task automatic send_string();
    for (int i = 0; i < text_q.size(); i++) begin
      // drop valid for a random gap
      while ($urandom_range(99) < gap_pct) begin
        in_valid     <= 1'b0;
        in_character <= 8'($urandom_range(255));
        @(posedge clk);
      end
      in_valid     <= 1'b1;
      in_character <= text_q[i];
      in_last_char <= (i == text_q.size() - 1);
      do @(posedge clk); while (in_stall);
      sb.note_char(text_q[i], i == text_q.size() - 1);
      chars_sent++;
    end
    strings_sent++;
  endtask

  // Result side: check accepted items, stall at random, one long hold-off
  initial begin : receiver
    int cycle;
    int results_seen;
    int hold_left;
    bit held;
    cycle        = 0;
    results_seen = 0;
    hold_left    = 0;
    held         = 1'b0;
    forever begin
      @(posedge clk);
      cycle++;
      if (rst_n && out_valid && !out_stall) begin
        sb.check_result(out_valid_res, out_status, out_day_value, out_month_value,
                        out_year_value);
        results_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (results_seen == 30 && !held) begin
        held      = 1'b1;
        hold_left = 300;
        out_stall <= 1'b1;
      end else if (cycle > 1000 && cycle < 1800) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 13);
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin : stimulus
    sb           = new();
    gap_pct      = 13;
    chars_sent   = 0;
    strings_sent = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_character = 8'h00;
    in_last_char = 1'b0;
    out_stall    = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: leap century, non-leap century, single zero byte, single 0xFF
    set_text("29/02/2000");
    send_string();
    set_text("29/02/1900");
    send_string();
    text_q = {8'h00};
    send_string();
    text_q = {8'hFF};
    send_string();

    // Random strings, with a calm stretch and one full drain
    while (chars_sent < 1300) begin
      gap_pct = (strings_sent > 40 && strings_sent < 80) ? 0 : 13;
      if (strings_sent == 90) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      build_random_string();
      send_string();
    end
    in_valid     <= 1'b0;
    in_last_char <= 1'b0;

    // Drain, then let the pipeline settle
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("date_string_validator_test: done, clean");
    end else begin
      $display("date_string_validator_test: done, errors");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin : watchdog
    #400000;
    $display("date_string_validator_test: done, errors");
    $finish;
  end

endmodule
